[src/clt_pkg.sv]
// Shared types and constants of the command line tokenizer.
package clt_pkg;

    localparam int ARG_LIMIT   = 16;
    localparam int TOKEN_LEN   = 256;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam int TOK_CNT_W = $clog2(ARG_LIMIT + 1);
    localparam int CHAR_W    = $clog2(TOKEN_LEN);
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W = $clog2(MAX_RESULTS);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_CMD_END   = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_GAP   = 2'd0,
        MODE_TOKEN = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_BLOCK = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_tok_request;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic [3:0] arg_index;
        logic [7:0] char_index;
        logic [4:0] arg_count;
        logic       quote_unclosed;
        logic       comment_unclosed;
        logic       args_dropped;
        logic       last_result;
    } t_tok_result;

    // All results caused by one script byte.
    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        t_tok_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

endpackage

[src/command_line_tokenizer_unit.sv]
// Top level of the command line tokenizer: scanner, bundle queue and output sequencer.
//
//   Channel   Valid         Stall         Payload   Moves
//   request   i_req_valid   o_req_stall   i_req     one script byte and its end-of-buffer mark
//   result    o_rsp_valid   i_rsp_stall   o_rsp     one token character, token end or command end
//
// The scanner takes one byte per cycle as long as the four-entry bundle queue has room.
// A byte that causes n results puts n results on the output; bytes with no result skip it.
// With the queue empty, the bundle of an accepted byte is written into the queue and then moves
// into the holding register, from which its first result is valid.
// Result stalls back up through the queue; the request side stalls only when the queue is full.
// Synchronous reset returns the scanner to the between-tokens state and empties the queue.
module command_line_tokenizer_unit import clt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    output logic         o_req_stall,
    input  t_tok_request i_req,
    output logic         o_rsp_valid,
    input  logic         i_rsp_stall,
    output t_tok_result  o_rsp
);

    logic    w_push;
    t_bundle w_push_data;
    logic    w_full;
    logic    w_q_valid;
    t_bundle w_q_head;
    logic    w_pop;

    clt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    clt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head),
        .i_pop       (w_pop)
    );

    clt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

[src/clt_front.sv]
// Front end: accepts script bytes, runs the scanner and builds the result bundle of each byte.
module clt_front import clt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    output logic         o_req_stall,
    input  t_tok_request i_req,
    input  logic         i_queue_full,
    output logic         o_push,
    output t_bundle      o_push_data
);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        t_scan_mode           mode;
        logic                 pending_slash;
        logic                 pending_star;
        logic                 token_quoted;
        logic [TOK_CNT_W-1:0] tokens_seen;
        logic [CHAR_W-1:0]    chars_in_token;
        logic                 dropped_flag;
    } t_scan_state;

    typedef struct packed {
        t_scan_state          st;
        logic                 end_pending;
        logic                 end_quote;
        logic [TOK_CNT_W-1:0] end_arg;
        logic [CHAR_W-1:0]    end_len;
        t_bundle              out;
    } t_ctx;

    localparam t_scan_state SCAN_RESET = '{MODE_GAP, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0};

    function automatic logic f_is_ctrl(logic [7:0] b);
        return (b != 8'd0) && (b < CH_SPACE);
    endfunction

    function automatic logic f_is_space(logic [7:0] b);
        return f_is_ctrl(b) || (b == CH_SPACE);
    endfunction

    function automatic t_ctx f_emit(t_ctx c, t_kind k, logic [7:0] b,
                                    logic [TOK_CNT_W-1:0] ai, logic [CHAR_W-1:0] ci,
                                    logic [TOK_CNT_W-1:0] ac, logic q, logic cm);
        t_ctx        r;
        t_tok_result e;
        r = c;
        e.kind             = k;
        e.out_byte         = b;
        e.arg_index        = 4'(ai);
        e.char_index       = 8'(ci);
        e.arg_count        = 5'(ac);
        e.quote_unclosed   = q;
        e.comment_unclosed = cm;
        e.args_dropped     = r.st.dropped_flag;
        e.last_result      = 1'b0;
        if (r.out.count < RES_CNT_W'(MAX_RESULTS)) begin
            r.out.res[r.out.count[RES_IDX_W-1:0]] = e;
            r.out.count = r.out.count + 1'b1;
        end
        return r;
    endfunction

    function automatic t_ctx f_flush_end(t_ctx c);
        t_ctx r;
        r = c;
        if (r.end_pending) begin
            r.end_pending = 1'b0;
            r = f_emit(r, KIND_TOKEN_END, 8'd0, r.end_arg, r.end_len, '0, r.end_quote, 1'b0);
        end
        return r;
    endfunction

    function automatic t_ctx f_end_token(t_ctx c, logic q);
        t_ctx r;
        r = f_flush_end(c);
        r.end_pending       = 1'b1;
        r.end_arg           = r.st.tokens_seen;
        r.end_len           = r.st.chars_in_token;
        r.end_quote         = q;
        r.st.tokens_seen    = r.st.tokens_seen + 1'b1;
        r.st.mode           = MODE_GAP;
        r.st.token_quoted   = 1'b0;
        r.st.chars_in_token = '0;
        return r;
    endfunction

    // A token closed by the byte that also ends the command gets no token end;
    // its quote flag moves onto the command end.
    function automatic t_ctx f_command_end(t_ctx c, logic q, logic cm);
        t_ctx r;
        logic qq;
        r  = c;
        qq = q;
        if (r.end_pending) begin
            qq = qq || r.end_quote;
            r.end_pending = 1'b0;
        end
        r = f_emit(r, KIND_CMD_END, 8'd0, '0, '0, r.st.tokens_seen, qq, cm);
        r.st.tokens_seen  = '0;
        r.st.dropped_flag = 1'b0;
        return r;
    endfunction

    function automatic t_ctx f_put_char(t_ctx c, logic [7:0] b);
        t_ctx r;
        r = f_flush_end(c);
        r = f_emit(r, KIND_CHAR, b, r.st.tokens_seen, r.st.chars_in_token, '0, 1'b0, 1'b0);
        r.st.chars_in_token = r.st.chars_in_token + 1'b1;
        if (!r.st.token_quoted && (r.st.chars_in_token >= CHAR_W'(TOKEN_LEN - 1))) begin
            r = f_end_token(r, 1'b0);
        end
        return r;
    endfunction

    function automatic t_ctx f_plain_char(t_ctx c, logic [7:0] b);
        t_ctx r;
        r = c;
        if (r.st.mode == MODE_GAP) begin
            if (r.st.tokens_seen >= TOK_CNT_W'(ARG_LIMIT)) begin
                r.st.dropped_flag = 1'b1;
                return r;
            end
            r.st.mode           = MODE_TOKEN;
            r.st.token_quoted   = 1'b0;
            r.st.chars_in_token = '0;
        end
        return f_put_char(r, b);
    endfunction

    function automatic t_ctx f_gap(t_ctx c, logic [7:0] b);
        t_ctx r;
        r = c;
        if (b == CH_SLASH) begin
            r.st.pending_slash = 1'b1;
        end else if ((b == CH_NL) || (b == CH_SEMI)) begin
            if (r.st.tokens_seen != '0) begin
                r = f_command_end(r, 1'b0, 1'b0);
            end
        end else if (f_is_space(b)) begin
            r = r;
        end else if (r.st.tokens_seen >= TOK_CNT_W'(ARG_LIMIT)) begin
            r.st.dropped_flag = 1'b1;
        end else if (b == CH_QUOTE) begin
            r.st.mode           = MODE_TOKEN;
            r.st.token_quoted   = 1'b1;
            r.st.chars_in_token = '0;
        end else begin
            r = f_plain_char(r, b);
        end
        return r;
    endfunction

    // Every rescan of a byte happens between tokens, so one pass plus a gap pass suffices.
    function automatic t_ctx f_process(t_ctx c, logic [7:0] b);
        t_ctx r;
        r = c;
        unique case (r.st.mode)
            MODE_LINE: begin
                if (b == CH_NL) begin
                    r.st.mode = MODE_GAP;
                    r = f_gap(r, b);
                end
            end
            MODE_BLOCK: begin
                if (r.st.pending_star && (b == CH_SLASH)) begin
                    r.st.mode         = MODE_GAP;
                    r.st.pending_star = 1'b0;
                end else begin
                    r.st.pending_star = (b == CH_STAR);
                end
            end
            MODE_TOKEN: begin
                if (r.st.token_quoted) begin
                    if (f_is_ctrl(b)) begin
                        r = f_end_token(r, 1'b1);
                        r = f_gap(r, b);
                    end else if (b == CH_QUOTE) begin
                        if (r.st.chars_in_token == '0) begin
                            r.st.mode         = MODE_GAP;
                            r.st.token_quoted = 1'b0;
                        end else begin
                            r = f_end_token(r, 1'b0);
                        end
                    end else if (r.st.chars_in_token >= CHAR_W'(TOKEN_LEN - 1)) begin
                        r = f_end_token(r, 1'b1);
                        r = f_gap(r, b);
                    end else begin
                        r = f_put_char(r, b);
                    end
                end else begin
                    if (b == CH_SLASH) begin
                        r.st.pending_slash = 1'b1;
                    end else if (f_is_space(b) || (b == CH_SEMI) || (b == CH_QUOTE)) begin
                        r = f_end_token(r, 1'b0);
                        r = f_gap(r, b);
                    end else begin
                        r = f_plain_char(r, b);
                    end
                end
            end
            default: begin
                r = f_gap(r, b);
            end
        endcase
        return r;
    endfunction

    function automatic t_ctx f_step(t_scan_state s, t_tok_request q);
        t_ctx r;
        logic fq;
        logic fc;
        r    = '0;
        r.st = s;
        fq   = 1'b0;
        fc   = 1'b0;
        if (r.st.pending_slash) begin
            r.st.pending_slash = 1'b0;
            if ((q.in_byte == CH_SLASH) || (q.in_byte == CH_STAR)) begin
                if (r.st.mode == MODE_TOKEN) begin
                    r = f_end_token(r, 1'b0);
                end
                r.st.mode         = (q.in_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                r.st.pending_star = 1'b0;
            end else begin
                r = f_plain_char(r, CH_SLASH);
                r = f_process(r, q.in_byte);
            end
        end else begin
            r = f_process(r, q.in_byte);
        end

        if (q.end_of_buffer) begin
            // A held slash at the end of a buffer is an ordinary character.
            if (r.st.pending_slash) begin
                r.st.pending_slash = 1'b0;
                r = f_plain_char(r, CH_SLASH);
            end
            if (r.st.mode == MODE_TOKEN) begin
                if (r.st.token_quoted) begin
                    if (r.st.chars_in_token == '0) begin
                        fq                = 1'b1;
                        r.st.mode         = MODE_GAP;
                        r.st.token_quoted = 1'b0;
                    end else begin
                        r = f_end_token(r, 1'b1);
                    end
                end else begin
                    r = f_end_token(r, 1'b0);
                end
            end
            fc = (r.st.mode == MODE_BLOCK);
            if (r.st.tokens_seen != '0) begin
                r = f_command_end(r, fq, fc);
            end else if (fq || fc) begin
                r = f_emit(r, KIND_NONE, 8'd0, '0, '0, '0, fq, fc);
            end
            r = f_flush_end(r);
            r.st = SCAN_RESET;
        end

        r = f_flush_end(r);
        if (r.out.count != '0) begin
            r.out.res[RES_IDX_W'(r.out.count - 1'b1)].last_result = 1'b1;
        end
        return r;
    endfunction

    t_scan_state r_state;
    t_ctx        n_ctx;
    logic        w_accept;

    always_comb begin
        n_ctx = f_step(r_state, i_req);
    end

    assign o_req_stall = i_queue_full;
    assign w_accept    = i_req_valid && !i_queue_full;
    assign o_push      = w_accept && (n_ctx.out.count != '0);
    assign o_push_data = n_ctx.out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (w_accept) begin
            r_state <= n_ctx.st;
        end
    end

endmodule

[src/clt_queue.sv]
// Short queue of result bundles between the scanner and the output sequencer.
module clt_queue import clt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_push_data,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_head,
    input  logic    i_pop
);

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            priority if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/clt_back.sv]
// Back end: hands out bundle results from a holding register, one per unstalled cycle.
module clt_back import clt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_bundle     i_q_head,
    output logic        o_pop,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output t_tok_result o_rsp
);

    t_bundle              r_bundle;
    logic                 r_have;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 w_take;
    logic                 w_done;

    assign o_rsp       = r_bundle.res[r_idx];
    assign o_rsp_valid = r_have;
    assign w_take      = r_have && !i_rsp_stall;
    // The bundle is used up once its final result has been taken.
    assign w_done      = !r_have || (w_take && o_rsp.last_result);
    assign o_pop       = w_done && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (w_done) begin
            r_have <= i_q_valid;
            r_idx  <= '0;
        end else if (w_take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

[sim/token_stream_checker.sv]
// Result checker for the command line tokenizer: predicts token output per request and compares.
module token_stream_checker import clt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_stall,
    input  t_tok_request i_req,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_stall,
    input  t_tok_result  i_rsp,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int MAX_REPORTS = 40;

    // Scanner state as the block should hold it.
    t_scan_mode  mode;
    bit          held_slash;
    bit          held_star;
    bit          in_quotes;
    int unsigned tokens_done;
    int unsigned token_chars;
    bit          dropping;

    // A token end is held back so that a command end in the same request can absorb it.
    bit          end_held;
    bit          end_quote;
    int unsigned end_arg;
    int unsigned end_len;

    t_tok_result request_results[$];
    t_tok_result expected_tokens[$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          queued         = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = queued;

    function automatic bit is_control(logic [7:0] b);
        return b >= 8'd1 && b < 8'd32;
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return is_control(b) || b == " ";
    endfunction

    function void clear_scanner();
        mode        = MODE_GAP;
        held_slash  = 1'b0;
        held_star   = 1'b0;
        in_quotes   = 1'b0;
        tokens_done = 0;
        token_chars = 0;
        dropping    = 1'b0;
        end_held    = 1'b0;
    endfunction

    function void add_result(t_kind k, logic [7:0] b, int unsigned ai, int unsigned ci,
                             int unsigned ac, bit q, bit c);
        t_tok_result r;
        if (request_results.size() < MAX_RESULTS) begin
            r.kind             = k;
            r.out_byte         = b;
            r.arg_index        = 4'(ai);
            r.char_index       = 8'(ci);
            r.arg_count        = 5'(ac);
            r.quote_unclosed   = q;
            r.comment_unclosed = c;
            r.args_dropped     = dropping;
            r.last_result      = 1'b0;
            request_results.push_back(r);
        end
    endfunction

    function void release_token_end();
        if (end_held) begin
            end_held = 1'b0;
            add_result(KIND_TOKEN_END, 8'h00, end_arg, end_len, 0, end_quote, 1'b0);
        end
    endfunction

    function void close_token(bit q);
        release_token_end();
        end_held    = 1'b1;
        end_arg     = tokens_done;
        end_len     = token_chars;
        end_quote   = q;
        tokens_done = tokens_done + 1;
        mode        = MODE_GAP;
        in_quotes   = 1'b0;
        token_chars = 0;
    endfunction

    function void close_command(bit q, bit c);
        bit flag;
        flag = q;
        if (end_held) begin
            flag     = flag | end_quote;
            end_held = 1'b0;
        end
        add_result(KIND_CMD_END, 8'h00, 0, 0, tokens_done, flag, c);
        tokens_done = 0;
        dropping    = 1'b0;
    endfunction

    function void add_token_char(logic [7:0] b);
        release_token_end();
        add_result(KIND_CHAR, b, tokens_done, token_chars, 0, 1'b0, 1'b0);
        token_chars = token_chars + 1;
        if (!in_quotes && token_chars >= TOKEN_LEN - 1)
            close_token(1'b0);
    endfunction

    function void take_plain(logic [7:0] b);
        if (mode == MODE_GAP) begin
            if (tokens_done >= ARG_LIMIT) begin
                dropping = 1'b1;
                return;
            end
            mode        = MODE_TOKEN;
            in_quotes   = 1'b0;
            token_chars = 0;
        end
        add_token_char(b);
    endfunction

    // A byte that closes a token or a line comment is looked at again in the new mode.
    function void scan_byte(logic [7:0] b);
        bit again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (mode == MODE_LINE) begin
                if (b == "\n") begin
                    mode  = MODE_GAP;
                    again = 1'b1;
                end
            end else if (mode == MODE_BLOCK) begin
                if (held_star && b == "/") begin
                    mode      = MODE_GAP;
                    held_star = 1'b0;
                end else begin
                    held_star = (b == "*");
                end
            end else if (mode == MODE_TOKEN && in_quotes) begin
                if (is_control(b)) begin
                    close_token(1'b1);
                    again = 1'b1;
                end else if (b == "\"") begin
                    if (token_chars == 0) begin
                        mode      = MODE_GAP;
                        in_quotes = 1'b0;
                    end else begin
                        close_token(1'b0);
                    end
                end else if (token_chars >= TOKEN_LEN - 1) begin
                    close_token(1'b1);
                    again = 1'b1;
                end else begin
                    add_token_char(b);
                end
            end else if (mode == MODE_TOKEN) begin
                if (b == "/") begin
                    held_slash = 1'b1;
                end else if (is_blank(b) || b == ";" || b == "\"") begin
                    close_token(1'b0);
                    again = 1'b1;
                end else begin
                    take_plain(b);
                end
            end else begin
                if (b == "/") begin
                    held_slash = 1'b1;
                end else if (b == "\n" || b == ";") begin
                    if (tokens_done > 0)
                        close_command(1'b0, 1'b0);
                end else if (!is_blank(b)) begin
                    if (tokens_done >= ARG_LIMIT) begin
                        dropping = 1'b1;
                    end else if (b == "\"") begin
                        mode        = MODE_TOKEN;
                        in_quotes   = 1'b1;
                        token_chars = 0;
                    end else begin
                        take_plain(b);
                    end
                end
            end
        end
    endfunction

    function void finish_buffer();
        bit q;
        bit c;
        q = 1'b0;
        c = 1'b0;
        if (held_slash) begin
            held_slash = 1'b0;
            take_plain("/");
        end
        if (mode == MODE_TOKEN) begin
            if (!in_quotes) begin
                close_token(1'b0);
            end else if (token_chars == 0) begin
                q         = 1'b1;
                mode      = MODE_GAP;
                in_quotes = 1'b0;
            end else begin
                close_token(1'b1);
            end
        end
        if (mode == MODE_BLOCK)
            c = 1'b1;
        if (tokens_done > 0)
            close_command(q, c);
        else if (q || c)
            add_result(KIND_NONE, 8'h00, 0, 0, 0, q, c);
        release_token_end();
        clear_scanner();
    endfunction

    function void predict_tokens_for_byte(t_tok_request r);
        logic [7:0] b;
        b        = r.in_byte;
        end_held = 1'b0;
        request_results.delete();
        if (held_slash) begin
            held_slash = 1'b0;
            if (b == "/" || b == "*") begin
                if (mode == MODE_TOKEN)
                    close_token(1'b0);
                mode      = (b == "/") ? MODE_LINE : MODE_BLOCK;
                held_star = 1'b0;
            end else begin
                take_plain("/");
                scan_byte(b);
            end
        end else begin
            scan_byte(b);
        end
        if (r.end_of_buffer)
            finish_buffer();
        release_token_end();
        if (request_results.size() > 0)
            request_results[request_results.size() - 1].last_result = 1'b1;
        foreach (request_results[k])
            expected_tokens.push_back(request_results[k]);
    endfunction

    task report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(input t_tok_result got);
        t_tok_result want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("no result expected, got kind %0d byte %0h",
                                      got.kind, got.out_byte));
        end else begin
            want = expected_tokens.pop_front();
            compare_field("kind", 8'(got.kind), 8'(want.kind));
            compare_field("out_byte", got.out_byte, want.out_byte);
            compare_field("arg_index", 8'(got.arg_index), 8'(want.arg_index));
            compare_field("char_index", got.char_index, want.char_index);
            compare_field("arg_count", 8'(got.arg_count), 8'(want.arg_count));
            compare_field("quote_unclosed", 8'(got.quote_unclosed), 8'(want.quote_unclosed));
            compare_field("comment_unclosed", 8'(got.comment_unclosed),
                          8'(want.comment_unclosed));
            compare_field("args_dropped", 8'(got.args_dropped), 8'(want.args_dropped));
            compare_field("last_result", 8'(got.last_result), 8'(want.last_result));
        end
        results_seen++;
    endtask

    initial clear_scanner();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scanner();
            expected_tokens.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                predict_tokens_for_byte(i_req);
            if (i_rsp_valid && !i_rsp_stall)
                check_result(i_rsp);
        end
        queued <= expected_tokens.size();
    end

endmodule

[sim/tb_command_line_tokenizer_unit.sv]
// Testbench top for the command line tokenizer: clock, reset, script stimulus and verdict.
module tb_command_line_tokenizer_unit;
    import clt_pkg::*;

    localparam int RANDOM_ITEMS    = 25;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 16;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_stall;
    t_tok_request req       = '0;
    logic         rsp_valid;
    logic         rsp_stall = 1'b0;
    t_tok_result  rsp;

    int fail_count;
    int pending_results;
    int sent_items    = 0;
    int quiet_cycles  = 0;
    bit steady_sender = 1'b0;
    bit squeeze_req   = 1'b0;

    command_line_tokenizer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    token_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= 8'd1 && b <= " ") || b == "/" || b == ";" || b == "\"");
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= 8'd1 && b < " ") || b == "\"");
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r < 5)
            return " ";
        if (r < 7)
            return "\t";
        return 8'($urandom_range(11, 31));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int           gap;
        t_tok_request r;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.in_byte       = b;
        r.end_of_buffer = eob;
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic eob_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eob_last && i == s.len() - 1);
    endtask

    // One command of random tokens, quoted tokens and comments, with a random terminator.
    task automatic send_command();
        int         n_tok;
        logic [7:0] cb;
        n_tok = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 4);
        for (int i = 0; i < n_tok; i++) begin
            if (i > 0 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_byte(blank_byte(), 1'b0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_byte("\"", 1'b0);
                    repeat ($urandom_range(0, 5)) send_byte(quoted_byte(), 1'b0);
                    send_byte("\"", 1'b0);
                end
                2: begin
                    send_text("/*", 1'b0);
                    repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    send_text("*/", 1'b0);
                    send_byte(plain_byte(), 1'b0);
                end
                3: begin
                    send_byte(plain_byte(), 1'b0);
                    send_byte("/", 1'b0);
                    send_byte(plain_byte(), 1'b0);
                end
                default: repeat ($urandom_range(1, 6)) send_byte(plain_byte(), 1'b0);
            endcase
        end
        case ($urandom_range(0, 5))
            0: send_byte(";", 1'b0);
            1: send_byte("\n", 1'b0);
            2: begin
                send_text("//", 1'b0);
                repeat ($urandom_range(0, 4)) begin
                    do cb = 8'($urandom_range(0, 255));
                    while (cb == "\n");
                    send_byte(cb, 1'b0);
                end
                send_byte("\n", 1'b0);
            end
            3: send_byte(plain_byte(), 1'b1);
            4: begin
                send_byte(blank_byte(), 1'b0);
                send_byte("\n", 1'b0);
            end
            default: send_byte(";", 1'b1);
        endcase
    endtask

    initial begin
        int stop_at;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero and high bytes as token characters; the command end closes the token.
        send_byte("a", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(";", 1'b0);
        // Empty quotes give no token, so the newline ends no command.
        send_text("\"\"\n", 1'b0);
        // Quote then tab, a quoted token, and a slash held at end of buffer.
        send_text("\"\t\"x\" /", 1'b1);
        // Lone unclosed quote, then lone unclosed block comment.
        send_byte("\"", 1'b1);
        send_text("/*", 1'b1);
        send_text("//\n", 1'b0);
        send_text("/**/k", 1'b1);

        // The receiver takes its long hold-off early in the random part.
        squeeze_req <= 1'b1;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 15) == 0)
                steady_sender = !steady_sender;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                send_command();
            end
        end
        steady_sender = 1'b0;

        // A quoted token at full length that runs into a plain byte, which starts a new token.
        send_byte(";", 1'b1);
        send_byte("\"", 1'b0);
        repeat (TOKEN_LEN - 1) send_byte(quoted_byte(), 1'b0);
        send_byte("x", 1'b0);
        send_byte(";", 1'b1);
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("command_line_tokenizer_unit test passed");
        else
            $display("command_line_tokenizer_unit test failed");
        $finish;
    end

    // Result side: runs of readiness and stalls, plus one long hold-off that fills the block.
    initial begin
        int run;
        int gap;
        bit squeezed;
        squeezed = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("command_line_tokenizer_unit test failed");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
src/clt_pkg.sv
src/clt_front.sv
src/clt_queue.sv
src/clt_back.sv
src/command_line_tokenizer_unit.sv
sim/token_stream_checker.sv
sim/tb_command_line_tokenizer_unit.sv
